// ===== rtl/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants for the SLIP frame decoder: byte codes,
// register indexes, result kinds, frame status codes and the result record.
// ----------------------------------------------------------------------------
package sfd_pkg;

	// SLIP byte codes
	localparam logic [7:0] SLIP_END     = 8'hC0;
	localparam logic [7:0] SLIP_ESC     = 8'hDB;
	localparam logic [7:0] SLIP_ESC_END = 8'hDC;
	localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 1'b1;

	// register reset values
	localparam logic [15:0] MIN_LEN_RST = 16'd20;
	localparam logic [15:0] MAX_LEN_RST = 16'd1006;

	// result kinds
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// frame status codes
	localparam logic [1:0] ST_DELIVERED = 2'd0;
	localparam logic [1:0] ST_SHORT     = 2'd1;
	localparam logic [1:0] ST_OVERRUN   = 2'd2;

	// one result beat
	typedef struct packed {
		logic        kind;
		logic [7:0]  data_byte;
		logic [1:0]  frame_status;
		logic [15:0] frame_length;
		logic [31:0] good_frames;
		logic [31:0] bad_frames;
	} sfd_result_t;

endpackage

// ===== rtl/slip_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// slip_frame_decoder
// SLIP receive deframer: streams de-escaped payload bytes and one frame-end
// beat per END byte with status, length and packet counters.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, rx_byte) takes one raw line byte per
//   beat. Output channel (out_valid/out_ready) gives zero or one beat per
//   byte: kind 0 is a decoded data byte, kind 1 a frame end carrying
//   frame_status, frame_length, good_frames and bad_frames. Downstream drops
//   the streamed bytes of any frame whose end is not marked delivered.
//   ESC bytes and bytes past max_packet_len give no beat.
//   Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
//   index 0 is min_packet_len, index 1 is max_packet_len. Write while idle.
//   Pipeline: a result beat passes the input register, then the output
//   register, before the receiver can take it. Throughput: one byte per
//   cycle while the receiver keeps up, set by the state update in the
//   decode stage.
//   Reset clears frame state and counters and loads 20 / 1006 into the
//   length registers. When the receiver stalls, the output register holds
//   its beat, one more byte waits in the input register, then in_ready drops.
// ----------------------------------------------------------------------------
module slip_frame_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    rx_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          kind,
	output logic [7:0]                    data_byte,
	output logic [1:0]                    frame_status,
	output logic [15:0]                   frame_length,
	output logic [31:0]                   good_frames,
	output logic [31:0]                   bad_frames,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data
);
	import sfd_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        adv;
	logic        res_valid;
	logic        can_load;
	sfd_result_t res;
	sfd_result_t out_q;

	sfd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	sfd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.valid_s1  (valid_s1),
		.byte_s1   (byte_s1),
		.can_load  (can_load),
		.adv       (adv),
		.res_valid (res_valid),
		.res       (res)
	);

	sfd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv && res_valid),
		.res       (res),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_q     (out_q)
	);

	assign kind         = out_q.kind;
	assign data_byte    = out_q.data_byte;
	assign frame_status = out_q.frame_status;
	assign frame_length = out_q.frame_length;
	assign good_frames  = out_q.good_frames;
	assign bad_frames   = out_q.bad_frames;

endmodule

// ===== rtl/sfd_in_stage.sv =====
// ----------------------------------------------------------------------------
// sfd_in_stage
// Input register: holds one received byte until the decode stage takes it.
// ----------------------------------------------------------------------------
module sfd_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       adv,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	// free when empty or when the held byte moves on this cycle
	assign in_ready = !valid_s1 || adv;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

`ifndef SYNTHESIS
	// a held byte that does not move stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(byte_s1))
		else $error("sfd_in_stage: held byte lost or changed");
`endif

endmodule

// ===== rtl/sfd_core.sv =====
// ----------------------------------------------------------------------------
// sfd_core
// Decode stage: configuration registers, frame state and counters, and the
// one-pass SLIP decode of the byte in the input register.
// ----------------------------------------------------------------------------
module sfd_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [15:0]                    cfg_data,
	input  logic                           valid_s1,
	input  logic [7:0]                     byte_s1,
	input  logic                           can_load,
	output logic                           adv,
	output logic                           res_valid,
	output sfd_pkg::sfd_result_t           res
);
	import sfd_pkg::*;

	logic [15:0] min_len_q;
	logic [15:0] max_len_q;
	logic        esc_q;
	logic        ovr_q;
	logic [15:0] len_q;
	logic [31:0] good_q;
	logic [31:0] err_q;

	logic        esc_d;
	logic        ovr_d;
	logic [15:0] len_d;
	logic [31:0] good_d;
	logic [31:0] err_d;
	logic        is_end;

	assign cfg_ready = 1'b1;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= MIN_LEN_RST;
			max_len_q <= MAX_LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MIN_LEN: min_len_q <= cfg_data;
				REG_MAX_LEN: max_len_q <= cfg_data;
				default:     ;
			endcase
		end
	end

	assign is_end = (byte_s1 == SLIP_END);

	// decode
	always_comb begin
		esc_d     = esc_q;
		ovr_d     = ovr_q;
		len_d     = len_q;
		good_d    = good_q;
		err_d     = err_q;
		res_valid = 1'b0;
		res       = '0;
		if (valid_s1) begin
			if (is_end) begin
				res_valid        = 1'b1;
				res.kind         = KIND_END;
				res.frame_length = len_q;
				if (len_q < min_len_q) begin
					res.frame_status = ST_SHORT;
				end else if (ovr_q) begin
					res.frame_status = ST_OVERRUN;
					err_d            = err_q + 32'd1;
				end else begin
					res.frame_status = ST_DELIVERED;
					good_d           = good_q + 32'd1;
				end
				res.good_frames = good_d;
				res.bad_frames  = err_d;
				len_d           = '0;
				ovr_d           = 1'b0;
				esc_d           = 1'b0;
			end else if (len_q >= max_len_q) begin
				// limit reached: drop and flag
				ovr_d = 1'b1;
			end else if (byte_s1 == SLIP_ESC) begin
				esc_d = 1'b1;
			end else begin
				res_valid = 1'b1;
				res.kind  = KIND_DATA;
				esc_d     = 1'b0;
				len_d     = len_q + 16'd1;
				if (esc_q && byte_s1 == SLIP_ESC_END) begin
					res.data_byte = SLIP_END;
				end else if (esc_q && byte_s1 == SLIP_ESC_ESC) begin
					res.data_byte = SLIP_ESC;
				end else begin
					res.data_byte = byte_s1;
				end
			end
		end
	end

	// a byte with no result never waits on the output register
	assign adv = valid_s1 && (!res_valid || can_load);

	// frame state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q  <= 1'b0;
			ovr_q  <= 1'b0;
			len_q  <= '0;
			good_q <= '0;
			err_q  <= '0;
		end else if (adv) begin
			esc_q  <= esc_d;
			ovr_q  <= ovr_d;
			len_q  <= len_d;
			good_q <= good_d;
			err_q  <= err_d;
		end
	end

`ifndef SYNTHESIS
	// frame end clears the frame state
	a_end_clear: assert property (@(posedge clk) disable iff (!arst_n)
		adv && is_end |=> len_q == '0 && !ovr_q && !esc_q)
		else $error("sfd_core: frame state not cleared at frame end");

	// counters move only on a frame end
	a_cnt_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!(adv && is_end) |=> $stable(good_q) && $stable(err_q))
		else $error("sfd_core: counter changed outside a frame end");
`endif

endmodule

// ===== rtl/sfd_out_stage.sv =====
// ----------------------------------------------------------------------------
// sfd_out_stage
// Output register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module sfd_out_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  sfd_pkg::sfd_result_t res,
	output logic                 can_load,
	output logic                 out_valid,
	input  logic                 out_ready,
	output sfd_pkg::sfd_result_t out_q
);
	import sfd_pkg::*;

	assign can_load = !out_valid || out_ready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res;
		end
	end

`ifndef SYNTHESIS
	// never overwrite a beat the receiver has not taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !out_valid || out_ready)
		else $error("sfd_out_stage: pending beat overwritten");
`endif

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SLIP frame decoder testbench
// Feeds raw line bytes (directed corner frames, then random frames that are
// mostly well formed) through the decoder under several length limits and
// idling patterns. Each data or frame-end beat is checked against a
// scoreboard that tracks escape, overrun, length and packet counters.
// ----------------------------------------------------------------------------
module testbench;
	import sfd_pkg::*;

	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned HOLD_CYCLES   = 200;
	localparam int unsigned QUIET_LIMIT   = 2000;

	// Tracks the deframer state and queues the beats it must produce
	class slip_deframe_board;
		logic [15:0] min_len;
		logic [15:0] max_len;
		bit          esc_pending;
		bit          overrun;
		logic [15:0] frame_len;
		logic [31:0] good_cnt;
		logic [31:0] bad_cnt;
		sfd_result_t expected_beats[$];
		int unsigned mismatch_count;

		function new();
			min_len        = MIN_LEN_RST;
			max_len        = MAX_LEN_RST;
			esc_pending    = 1'b0;
			overrun        = 1'b0;
			frame_len      = '0;
			good_cnt       = '0;
			bad_cnt        = '0;
			mismatch_count = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
			if (idx == REG_MIN_LEN)
				min_len = value;
			else if (idx == REG_MAX_LEN)
				max_len = value;
		endfunction

		// one accepted line byte: update state, queue the beat it causes
		function void deframe_byte(logic [7:0] rx);
			sfd_result_t beat;
			beat = '0;
			if (rx == SLIP_END) begin
				beat.kind = KIND_END;
				// too short wins over overrun
				if (frame_len < min_len) begin
					beat.frame_status = ST_SHORT;
				end else if (overrun) begin
					bad_cnt++;
					beat.frame_status = ST_OVERRUN;
				end else begin
					good_cnt++;
					beat.frame_status = ST_DELIVERED;
				end
				beat.frame_length = frame_len;
				beat.good_frames  = good_cnt;
				beat.bad_frames   = bad_cnt;
				expected_beats.push_back(beat);
				frame_len   = '0;
				overrun     = 1'b0;
				esc_pending = 1'b0;
			end else if (frame_len >= max_len) begin
				// limit reached: dropped, escape flag untouched
				overrun = 1'b1;
			end else if (rx == SLIP_ESC) begin
				esc_pending = 1'b1;
			end else begin
				beat.kind      = KIND_DATA;
				beat.data_byte = rx;
				if (esc_pending) begin
					esc_pending = 1'b0;
					if (rx == SLIP_ESC_END)
						beat.data_byte = SLIP_END;
					else if (rx == SLIP_ESC_ESC)
						beat.data_byte = SLIP_ESC;
				end
				frame_len++;
				expected_beats.push_back(beat);
			end
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				mismatch_count++;
			end
		endfunction

		function void check_beat(sfd_result_t got);
			sfd_result_t want;
			if (expected_beats.size() == 0) begin
				$error("unexpected result beat, kind %0d", got.kind);
				mismatch_count++;
				return;
			end
			want = expected_beats.pop_front();
			compare_field("kind", 32'(want.kind), 32'(got.kind));
			compare_field("data_byte", 32'(want.data_byte), 32'(got.data_byte));
			compare_field("frame_status", 32'(want.frame_status),
				32'(got.frame_status));
			compare_field("frame_length", 32'(want.frame_length),
				32'(got.frame_length));
			compare_field("good_frames", want.good_frames, got.good_frames);
			compare_field("bad_frames", want.bad_frames, got.bad_frames);
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n       = 1'b0;
	logic                 in_valid     = 1'b0;
	logic                 in_ready;
	logic [7:0]           rx_byte      = '0;
	logic                 out_valid;
	logic                 out_ready    = 1'b0;
	logic                 kind;
	logic [7:0]           data_byte;
	logic [1:0]           frame_status;
	logic [15:0]          frame_length;
	logic [31:0]          good_frames;
	logic [31:0]          bad_frames;
	logic                 cfg_valid    = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [15:0]          cfg_data     = '0;

	slip_deframe_board board = new();
	int unsigned       items_sent     = 0;
	int unsigned       send_idle_pct  = 0;
	int unsigned       recv_stall_pct = 0;
	bit                hold_request   = 1'b0;

	slip_frame_decoder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.data_byte    (data_byte),
		.frame_status (frame_status),
		.frame_length (frame_length),
		.good_frames  (good_frames),
		.bad_frames   (bad_frames),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Offer one line byte, with random idle cycles ahead of it.
	// Called right after a rising edge; returns at the accepting edge.
	task automatic send_byte(input logic [7:0] rx);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= rx;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.deframe_byte(rx);
		items_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		board.write_reg(idx, value);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// all beats back, then let bytes without a beat clear the pipeline
	task automatic wait_drained();
		while (board.expected_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [15:0] min_len, input logic [15:0] max_len);
		in_valid <= 1'b0;
		wait_drained();
		write_reg(REG_MIN_LEN, min_len);
		write_reg(REG_MAX_LEN, max_len);
	endtask

	// One frame: an occasional burst of line noise, then a payload with
	// proper escaping, now and then an ESC followed by a random byte,
	// closed by END.
	task automatic send_frame(input int unsigned len_cap);
		int unsigned n;
		int unsigned pick;
		logic [7:0]  b;
		if ($urandom_range(15) == 0)
			repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
		n = $urandom_range(len_cap);
		repeat (n) begin
			pick = $urandom_range(15);
			b = (pick == 0) ? SLIP_END : (pick == 1) ? SLIP_ESC
				: 8'($urandom_range(255));
			if (pick == 2) begin
				send_byte(SLIP_ESC);
				send_byte(b);
			end else if (b == SLIP_END) begin
				send_byte(SLIP_ESC);
				send_byte(SLIP_ESC_END);
			end else if (b == SLIP_ESC) begin
				send_byte(SLIP_ESC);
				send_byte(SLIP_ESC_ESC);
			end else begin
				send_byte(b);
			end
		end
		send_byte(SLIP_END);
	endtask

	task automatic run_phase(input logic [15:0] min_len, input logic [15:0] max_len,
			input int unsigned send_idle, input int unsigned recv_stall,
			input int unsigned target, input bit with_hold);
		int unsigned stop_at;
		int unsigned len_cap;
		len_cap = (max_len > 21) ? 24 : max_len + 3;
		configure(min_len, max_len);
		send_idle_pct  = send_idle;
		recv_stall_pct = recv_stall;
		stop_at = items_sent + target;
		while (items_sent < stop_at) begin
			// halfway through, have the receiver back off for a while
			if (with_hold && items_sent >= stop_at - target / 2) begin
				hold_request = 1'b1;
				with_hold    = 1'b0;
			end
			send_frame(len_cap);
		end
	endtask

	// Receiver: random stalls, an occasional long hold-off, check each beat
	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				repeat (HOLD_CYCLES) begin
					out_ready <= 1'b0;
					@(posedge clk);
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
			@(posedge clk);
			if (out_valid && out_ready)
				board.check_beat({kind, data_byte, frame_status, frame_length,
					good_frames, bad_frames});
		end
	end

	// Watchdog: too long with no beat on any channel
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
					|| (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Mismatches found");
		$finish;
	end

	// Main sequence
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limits: empty frame, byte extremes, both escapes,
		// escape of a plain byte, ESC right before END
		send_byte(SLIP_END);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(SLIP_ESC);
		send_byte(SLIP_ESC_END);
		send_byte(SLIP_ESC);
		send_byte(SLIP_ESC_ESC);
		send_byte(SLIP_ESC);
		send_byte(8'h41);
		send_byte(SLIP_ESC);
		send_byte(SLIP_END);

		// zero limit: every byte overruns; then an empty frame is delivered
		configure(16'd0, 16'd0);
		send_byte(8'h55);
		send_byte(SLIP_END);
		send_byte(SLIP_END);

		// overrun frame that is still too short
		configure(16'd5, 16'd3);
		send_byte(8'h01);
		send_byte(8'h02);
		send_byte(8'h03);
		send_byte(8'h04);
		send_byte(SLIP_END);

		// ESC at the limit overruns; then a delivered frame
		configure(16'd2, 16'd3);
		send_byte(8'h01);
		send_byte(8'h02);
		send_byte(8'h03);
		send_byte(SLIP_ESC);
		send_byte(SLIP_END);
		send_byte(8'h05);
		send_byte(8'h06);
		send_byte(SLIP_END);

		// random frames under several limits and idling patterns
		run_phase(16'd3, 16'd12, 0, 0, 150, 1'b0);
		run_phase(16'd0, 16'd1, 79, 0, 100, 1'b0);
		run_phase(16'hFFFF, 16'hFFFF, 0, 79, 120, 1'b0);
		run_phase(16'd6, 16'd20, 36, 36, 200, 1'b1);
		run_phase(MIN_LEN_RST, MAX_LEN_RST, 0, 0, 150, 1'b0);

		in_valid <= 1'b0;
		wait_drained();
		if (board.mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
